### rtl/udpc_pkg.sv
// Shared constants and types for the uplink DSCP priority classifier
package udpc_pkg;

  localparam int NUM_CHANNELS    = 8;
  localparam int MASK_CHANNELS   = 8;
  localparam int CH_IDX_W        = 3;
  localparam int CH_W            = 5;
  localparam int DSCP_W          = 6;
  localparam int LEN_W           = 16;
  localparam int LEN_OUT_W       = 17;
  localparam int IPV4_MIN_LENGTH = 20;
  localparam int IPV6_MIN_LENGTH = 40;
  localparam int QFI_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 48;
  localparam int IN_DATA_W       = 56;
  localparam int OUT_DATA_W      = 40;

  localparam logic [3:0] VERSION_IPV4 = 4'd4;
  localparam logic [3:0] VERSION_IPV6 = 4'd6;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PHASE_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BEARER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QFI_TABLE      = 3'd4;

  typedef struct packed {
    logic                 ch_ok;
    logic [CH_IDX_W-1:0]  idx;
    logic                 dscp_valid;
    logic [DSCP_W-1:0]    dscp_value;
    logic                 long_enough;
    logic                 header_added;
    logic [7:0]           header_byte;
    logic                 headroom_error;
    logic [LEN_OUT_W-1:0] length_out;
  } parse_t;

endpackage

### rtl/udpc_parse.sv
// Header parse: DSCP extraction, phase length check and uplink header build
module udpc_parse (
  input  logic [udpc_pkg::CH_W-1:0]   channel,
  input  logic [7:0]                  first_byte,
  input  logic [7:0]                  second_byte,
  input  logic [udpc_pkg::LEN_W-1:0]  packet_length,
  input  logic [udpc_pkg::LEN_W-1:0]  headroom,
  input  logic [udpc_pkg::LEN_W-1:0]  min_phase_length,
  input  logic [7:0]                  header_enable_mask,
  input  logic [7:0]                  data_bearer_mask,
  input  logic [udpc_pkg::CFG_DATA_W-1:0] qfi_table,
  output udpc_pkg::parse_t            res
);

  logic [3:0]                    version;
  logic                          ch_ok;
  logic                          ch_mask_ok;
  logic [udpc_pkg::CH_IDX_W-1:0] idx;
  logic [udpc_pkg::QFI_W-1:0]    qfi;
  logic                          hdr_want;

  assign version    = first_byte[7:4];
  assign idx        = channel[udpc_pkg::CH_IDX_W-1:0];
  assign ch_ok      = {1'b0, channel} < 6'(udpc_pkg::NUM_CHANNELS);
  assign ch_mask_ok = {1'b0, channel} < 6'(udpc_pkg::MASK_CHANNELS);
  assign hdr_want   = ch_ok && ch_mask_ok && header_enable_mask[idx];

  always_comb begin
    qfi = '0;
    for (int i = 0; i < udpc_pkg::MASK_CHANNELS; i++) begin
      if (idx == udpc_pkg::CH_IDX_W'(i)) begin
        qfi = qfi_table[i*udpc_pkg::QFI_W +: udpc_pkg::QFI_W];
      end
    end
  end

  always_comb begin
    res             = '0;
    res.ch_ok       = ch_ok;
    res.idx         = idx;
    res.long_enough = packet_length >= min_phase_length;
    res.length_out  = {1'b0, packet_length};
    if (packet_length >= udpc_pkg::LEN_W'(udpc_pkg::IPV4_MIN_LENGTH)) begin
      if (version == udpc_pkg::VERSION_IPV4) begin
        res.dscp_valid = 1'b1;
        res.dscp_value = second_byte[7:2];
      end else if (version == udpc_pkg::VERSION_IPV6 &&
                   packet_length >= udpc_pkg::LEN_W'(udpc_pkg::IPV6_MIN_LENGTH)) begin
        res.dscp_valid = 1'b1;
        res.dscp_value = {first_byte[3:0], second_byte[7:6]};
      end
    end
    if (hdr_want) begin
      if (headroom > udpc_pkg::LEN_W'(1)) begin
        res.header_added = 1'b1;
        res.header_byte  = {data_bearer_mask[idx], 1'b0, qfi};
        res.length_out   = {1'b0, packet_length} + udpc_pkg::LEN_OUT_W'(1);
      end else begin
        res.headroom_error = 1'b1;
      end
    end
  end

endmodule

### rtl/udpc_phase_mem.sv
// Per-channel DSCP phase store with registered read and write forwarding
module udpc_phase_mem (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [udpc_pkg::CH_IDX_W-1:0]   rd_idx,
  input  logic                            wr_en,
  input  logic [udpc_pkg::CH_IDX_W-1:0]   wr_idx,
  input  logic [udpc_pkg::DSCP_W-1:0]     wr_dscp,
  output logic                            rd_valid,
  output logic [udpc_pkg::DSCP_W-1:0]     rd_dscp
);

  logic [udpc_pkg::DSCP_W-1:0]   mem [udpc_pkg::NUM_CHANNELS];
  logic [udpc_pkg::NUM_CHANNELS-1:0] vld;
  logic [udpc_pkg::DSCP_W-1:0]   rdata;
  logic [udpc_pkg::CH_IDX_W-1:0] idx_q;
  logic                          fwd_hit;
  logic [udpc_pkg::DSCP_W-1:0]   fwd_dscp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_dscp;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx_q    <= rd_idx;
      fwd_hit  <= wr_en && (wr_idx == rd_idx);
      fwd_dscp <= wr_dscp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  assign rd_valid = vld[idx_q];
  assign rd_dscp  = fwd_hit ? fwd_dscp : rdata;

endmodule

### rtl/uplink_dscp_priority_classifier.sv
// Top level: stream ports, configuration registers and two-stage pipeline
// Each word passes stage one, where its phase is read, then the output register.
// Throughput: one word per cycle unless the output stalls; the phase memory read of
// one word overlaps the last one's write-back, forwarded when both hit the same channel.
// Reset clears the configuration, pipeline valids and all phase valid bits at once.
// While disabled, input words are accepted and dropped without a result.
module uplink_dscp_priority_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // channel[4:0], first_byte[12:5], second_byte[20:13], packet_length[36:21],
  // headroom[52:37], zero fill[55:53]
  input  logic [udpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // priority_res[0], dscp_valid[1], dscp_value[7:2], header_added[8],
  // header_byte[16:9], headroom_error[17], length_out[34:18], zero fill[39:35]
  output logic [udpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [udpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [udpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                              enabled;
  logic [udpc_pkg::LEN_W-1:0]        min_phase_length;
  logic [7:0]                        header_enable_mask;
  logic [7:0]                        data_bearer_mask;
  logic [udpc_pkg::CFG_DATA_W-1:0]   qfi_table;

  udpc_pkg::parse_t                  parse_res;
  udpc_pkg::parse_t                  s1;
  logic                              s1_valid;
  logic                              s1_adv;
  logic                              in_acc;
  logic                              phase_we;
  logic                              rd_valid;
  logic [udpc_pkg::DSCP_W-1:0]       rd_dscp;
  logic                              prio;
  logic [udpc_pkg::OUT_DATA_W-1:0]   out_data;
  logic                              out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled            <= 1'b0;
      min_phase_length   <= '0;
      header_enable_mask <= '0;
      data_bearer_mask   <= '0;
      qfi_table          <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        udpc_pkg::REG_ENABLED:       enabled            <= cfg_data[0];
        udpc_pkg::REG_MIN_PHASE_LEN: min_phase_length   <= cfg_data[15:0];
        udpc_pkg::REG_HEADER_ENABLE: header_enable_mask <= cfg_data[7:0];
        udpc_pkg::REG_DATA_BEARER:   data_bearer_mask   <= cfg_data[7:0];
        udpc_pkg::REG_QFI_TABLE:     qfi_table          <= cfg_data;
        default: ;
      endcase
    end
  end

  udpc_parse u_parse (
    .channel            (s_axis_tdata[4:0]),
    .first_byte         (s_axis_tdata[12:5]),
    .second_byte        (s_axis_tdata[20:13]),
    .packet_length      (s_axis_tdata[36:21]),
    .headroom           (s_axis_tdata[52:37]),
    .min_phase_length   (min_phase_length),
    .header_enable_mask (header_enable_mask),
    .data_bearer_mask   (data_bearer_mask),
    .qfi_table          (qfi_table),
    .res                (parse_res)
  );

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready && enabled;

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1 <= parse_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= in_acc;
    end
  end

  assign phase_we = s1_adv && s1.dscp_valid && s1.ch_ok && s1.long_enough;

  udpc_phase_mem u_phase_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s_axis_tready),
    .rd_idx   (parse_res.idx),
    .wr_en    (phase_we),
    .wr_idx   (s1.idx),
    .wr_dscp  (s1.dscp_value),
    .rd_valid (rd_valid),
    .rd_dscp  (rd_dscp)
  );

  assign prio = s1.dscp_valid && s1.ch_ok &&
                (s1.long_enough || (rd_valid && (rd_dscp == s1.dscp_value)));

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= {5'b0, s1.length_out, s1.headroom_error, s1.header_byte,
                   s1.header_added, s1.dscp_value, s1.dscp_valid, prio};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
